// File: rtl/ttb_pkg.sv
// Shared types, widths and register codes for the tensor transpose buffer.
package ttb_pkg;

  // Storage and rank limits
  localparam int MAX_RANK = 6;
  localparam int NUM_DIMS = 6;
  localparam int DEPTH    = 4096;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = $clog2(DEPTH);

  // Field widths of the request and result items
  localparam int ACT_W     = 1;
  localparam int OFF_W     = 12;
  localparam int VALUE_W   = 64;
  localparam int IN_DATA_W = ((OFF_W + VALUE_W + 7) / 8) * 8;

  // Configuration register widths
  localparam int RANK_W     = 3;
  localparam int SIZE_W     = 13;
  localparam int SEL_W      = 3;
  localparam int PERM_W     = NUM_DIMS * SEL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PERM_W;

  // Index widths for dimension counters and divider steps
  localparam int DIM_W  = $clog2(NUM_DIMS);
  localparam int STEP_W = $clog2(OFF_W);

  // Saturation point for element counts, strides and source offsets
  localparam int OFF_LIM = 1 << OFF_W;
  localparam int CAP     = (DEPTH > OFF_LIM) ? DEPTH : OFF_LIM;
  localparam int CAP_W   = $clog2(CAP) + 1;

  // Effective rank limit
  localparam int RANK_LIM = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;

  // Request kinds
  localparam logic [ACT_W-1:0] ACT_LOAD  = 1'b0;
  localparam logic [ACT_W-1:0] ACT_FETCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE5 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM  = 3'd7;

  // Result status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_DECIDE,
    S_SPLIT,
    S_DIV,
    S_SCAT,
    S_COMB,
    S_CHECK,
    S_RDATA,
    S_OUT
  } state_t;

endpackage

// File: rtl/tensor_transpose_buffer.sv
// Top level of the N-dimensional tensor transpose buffer.
//
// Usage:
//   Configure rank, the six source extents and the permutation on the cfg_
//   channel (always ready) while the block is idle. Then stream requests on
//   in_: a load request (tuser 0) stores tdata's value at a row-major source
//   offset; a fetch request (tuser 1) gives a row-major offset into the
//   permuted output tensor and returns the source element that lands there.
//   Every request yields exactly one result on out_: tdata is the element
//   (zero for loads and errors), tuser is the status (1 = offset out of range).
// Sequencing (r = rank in use, 1..6):
//   One request is in flight at a time. A load walks the r extents for the
//   element count, then checks the offset and writes the RAM. A fetch also
//   walks the extents, then splits the offset with the shared radix-2 divider
//   (12 steps per output dimension), does one multiply-accumulate per dimension
//   to rebuild the source offset and ends with one registered RAM read.
// Reset (rst_n low, synchronous): rank 2, all extents 1, perm field 0 = 1, others 0;
//   the element RAM is not cleared, so fetch only entries that were loaded.
// Stall: a finished result sits in the output register; in_tready stays
//   high for the next request while out_tvalid waits for out_tready.
module tensor_transpose_buffer (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ttb_pkg::IN_DATA_W-1:0]       in_tdata,  // [11:0] offset, [75:12] value, rest 0
  input  logic [ttb_pkg::ACT_W-1:0]           in_tuser,  // [0] action
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ttb_pkg::VALUE_W-1:0]         out_tdata, // [63:0] data
  output logic                                out_tuser, // [0] status
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CAP_W  = ttb_pkg::CAP_W;
  localparam int SIZE_W = ttb_pkg::SIZE_W;
  localparam int OFF_W  = ttb_pkg::OFF_W;
  localparam int DIM_W  = ttb_pkg::DIM_W;
  localparam int ND     = ttb_pkg::NUM_DIMS;

  // Saturating multiply of a running product by one extent
  function automatic logic [CAP_W-1:0] cap_mul(input logic [CAP_W-1:0]  a,
                                               input logic [SIZE_W-1:0] b);
    logic [CAP_W+SIZE_W-1:0] p;
    p = (CAP_W+SIZE_W)'(a) * (CAP_W+SIZE_W)'(b);
    if (p > (CAP_W+SIZE_W)'(ttb_pkg::CAP)) begin
      return CAP_W'(ttb_pkg::CAP);
    end
    return p[CAP_W-1:0];
  endfunction

  // Configuration registers
  logic [ttb_pkg::RANK_W-1:0] rank_r;
  logic [SIZE_W-1:0]          size_r [ND];
  logic [ttb_pkg::PERM_W-1:0] perm_r;

  // Sequencer state
  ttb_pkg::state_t state_r, state_nxt;

  // Request latch
  logic [ttb_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic [OFF_W-1:0]           off_r, off_nxt;
  logic [ttb_pkg::DATA_W-1:0] val_r, val_nxt;

  // Offset arithmetic
  logic [CAP_W-1:0]  count_r, count_nxt;
  logic [DIM_W-1:0]  dim_r, dim_nxt;
  logic [OFF_W-1:0]  rem_r, rem_nxt;
  logic [SIZE_W-1:0] ext_r, ext_nxt;
  logic [OFF_W-1:0]  div_q_r, div_q_nxt;
  logic [SIZE_W-1:0] div_p_r, div_p_nxt;
  logic [ttb_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [SIZE_W-1:0] src_idx_r [ND];
  logic [SIZE_W-1:0] src_idx_nxt [ND];
  logic [ND-1:0]     taken_r, taken_nxt;
  logic [CAP_W-1:0]  src_off_r, src_off_nxt;
  logic [CAP_W-1:0]  stride_r, stride_nxt;

  // Result and output registers
  logic [ttb_pkg::VALUE_W-1:0] res_data_r, res_data_nxt;
  logic                        res_status_r, res_status_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [ttb_pkg::VALUE_W-1:0] out_data_r, out_data_nxt;
  logic                        out_status_r, out_status_nxt;

  // Combinational helpers
  logic [ttb_pkg::RANK_W-1:0] urank;
  logic [ttb_pkg::RANK_W-1:0] urank_m1;
  logic [ttb_pkg::SEL_W-1:0]  sel_cur;
  logic                       sel_ok;
  logic [DIM_W-1:0]           size_idx;
  logic [SIZE_W-1:0]          size_rd;
  logic [SIZE_W-1:0]          ext_val;
  logic [SIZE_W:0]            div_t;
  logic [SIZE_W:0]            div_diff;
  logic                       div_ge;
  logic [CAP_W-1:0]           off_cap;
  logic [CAP_W-1:0]           count_mul;
  logic [CAP_W-1:0]           stride_mul;
  logic [CAP_W+SIZE_W:0]      src_sum;
  logic [CAP_W-1:0]           src_sum_cap;

  // RAM port signals
  logic                        ram_we;
  logic                        ram_re;
  logic [ttb_pkg::ADDR_W-1:0]  ram_waddr;
  logic [ttb_pkg::ADDR_W-1:0]  ram_raddr;
  logic [ttb_pkg::DATA_W-1:0]  ram_rd_data;

  assign in_tready  = (state_r == ttb_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Clamp rank: zero acts as one, anything above the limit as the limit
  always_comb begin
    urank = rank_r;
    if (rank_r == '0) begin
      urank = ttb_pkg::RANK_W'(1);
    end
    if (urank > ttb_pkg::RANK_W'(ttb_pkg::RANK_LIM)) begin
      urank = ttb_pkg::RANK_W'(ttb_pkg::RANK_LIM);
    end
  end
  assign urank_m1 = urank - ttb_pkg::RANK_W'(1);

  // Perm field of the output dimension being split
  assign sel_cur = perm_r[dim_r*ttb_pkg::SEL_W +: ttb_pkg::SEL_W];
  assign sel_ok  = (sel_cur < urank);

  // One read port on the extents: perm-selected while splitting, else by dim
  assign size_idx = (state_r == ttb_pkg::S_SPLIT) ? DIM_W'(sel_cur) : dim_r;
  assign size_rd  = size_r[size_idx];
  assign ext_val  = (!sel_ok || size_rd == '0) ? SIZE_W'(1) : size_rd;

  // Restoring divider step: shift in next dividend bit, try subtract
  assign div_t    = {div_p_r, div_q_r[OFF_W-1]};
  assign div_ge   = (div_t >= {1'b0, ext_r});
  assign div_diff = div_t - {1'b0, ext_r};

  assign off_cap    = CAP_W'(off_r);
  assign count_mul  = cap_mul(count_r, size_rd);
  assign stride_mul = cap_mul(stride_r, size_rd);

  // Source offset accumulate, saturating
  always_comb begin
    src_sum = (CAP_W+SIZE_W+1)'(src_off_r)
            + (CAP_W+SIZE_W+1)'(src_idx_r[dim_r]) * (CAP_W+SIZE_W+1)'(stride_r);
    if (src_sum > (CAP_W+SIZE_W+1)'(ttb_pkg::CAP)) begin
      src_sum_cap = CAP_W'(ttb_pkg::CAP);
    end else begin
      src_sum_cap = src_sum[CAP_W-1:0];
    end
  end

  assign ram_waddr = off_cap[ttb_pkg::ADDR_W-1:0];
  assign ram_raddr = src_off_r[ttb_pkg::ADDR_W-1:0];

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    off_nxt        = off_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    dim_nxt        = dim_r;
    rem_nxt        = rem_r;
    ext_nxt        = ext_r;
    div_q_nxt      = div_q_r;
    div_p_nxt      = div_p_r;
    step_nxt       = step_r;
    src_idx_nxt    = src_idx_r;
    taken_nxt      = taken_r;
    src_off_nxt    = src_off_r;
    stride_nxt     = stride_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    // Drop the result once the receiver takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ttb_pkg::S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tuser;
          off_nxt   = in_tdata[OFF_W-1:0];
          val_nxt   = in_tdata[OFF_W +: ttb_pkg::DATA_W];
          count_nxt = CAP_W'(1);
          dim_nxt   = '0;
          state_nxt = ttb_pkg::S_COUNT;
        end
      end

      // Element count over the dimensions in use, one extent per cycle
      ttb_pkg::S_COUNT: begin
        count_nxt = count_mul;
        if (dim_r == DIM_W'(urank_m1)) begin
          state_nxt = ttb_pkg::S_DECIDE;
        end else begin
          dim_nxt = dim_r + DIM_W'(1);
        end
      end

      ttb_pkg::S_DECIDE: begin
        res_data_nxt   = '0;
        res_status_nxt = ttb_pkg::STAT_OK;
        if (act_r == ttb_pkg::ACT_LOAD) begin
          if (off_cap >= count_r || off_cap >= CAP_W'(ttb_pkg::DEPTH)) begin
            res_status_nxt = ttb_pkg::STAT_ERR;
          end else begin
            ram_we = 1'b1;
          end
          state_nxt = ttb_pkg::S_OUT;
        end else if (off_cap >= count_r) begin
          res_status_nxt = ttb_pkg::STAT_ERR;
          state_nxt      = ttb_pkg::S_OUT;
        end else begin
          dim_nxt   = DIM_W'(urank_m1);
          rem_nxt   = off_r;
          taken_nxt = '0;
          for (int d = 0; d < ND; d++) begin
            src_idx_nxt[d] = '0;
          end
          state_nxt = ttb_pkg::S_SPLIT;
        end
      end

      // Load the divider for the current output dimension
      ttb_pkg::S_SPLIT: begin
        ext_nxt   = ext_val;
        div_q_nxt = rem_r;
        div_p_nxt = '0;
        step_nxt  = '0;
        state_nxt = ttb_pkg::S_DIV;
      end

      ttb_pkg::S_DIV: begin
        div_q_nxt = {div_q_r[OFF_W-2:0], div_ge};
        div_p_nxt = div_ge ? div_diff[SIZE_W-1:0] : div_t[SIZE_W-1:0];
        step_nxt  = step_r + ttb_pkg::STEP_W'(1);
        if (step_r == ttb_pkg::STEP_W'(OFF_W - 1)) begin
          state_nxt = ttb_pkg::S_SCAT;
        end
      end

      // Scatter the remainder; splitting runs downward, so the first write
      // to a source dimension is the one from the highest output dimension
      ttb_pkg::S_SCAT: begin
        rem_nxt = div_q_r;
        if (sel_ok && !taken_r[DIM_W'(sel_cur)]) begin
          src_idx_nxt[DIM_W'(sel_cur)] = div_p_r;
          taken_nxt[DIM_W'(sel_cur)]   = 1'b1;
        end
        if (dim_r == '0) begin
          dim_nxt     = DIM_W'(urank_m1);
          src_off_nxt = '0;
          stride_nxt  = CAP_W'(1);
          state_nxt   = ttb_pkg::S_COMB;
        end else begin
          dim_nxt   = dim_r - DIM_W'(1);
          state_nxt = ttb_pkg::S_SPLIT;
        end
      end

      // Rebuild the row-major source offset, innermost dimension first
      ttb_pkg::S_COMB: begin
        src_off_nxt = src_sum_cap;
        stride_nxt  = stride_mul;
        if (dim_r == '0) begin
          state_nxt = ttb_pkg::S_CHECK;
        end else begin
          dim_nxt = dim_r - DIM_W'(1);
        end
      end

      ttb_pkg::S_CHECK: begin
        if (src_off_r >= count_r || src_off_r >= CAP_W'(ttb_pkg::DEPTH)) begin
          res_status_nxt = ttb_pkg::STAT_ERR;
          state_nxt      = ttb_pkg::S_OUT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ttb_pkg::S_RDATA;
        end
      end

      ttb_pkg::S_RDATA: begin
        res_data_nxt = ttb_pkg::VALUE_W'(ram_rd_data);
        state_nxt    = ttb_pkg::S_OUT;
      end

      // Hold the result until the output register is free
      ttb_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          state_nxt      = ttb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ttb_pkg::S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ttb_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
      rank_r       <= ttb_pkg::RANK_W'(2);
      perm_r       <= ttb_pkg::PERM_W'(1);
      for (int d = 0; d < ND; d++) begin
        size_r[d] <= SIZE_W'(1);
      end
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index) inside
          ttb_pkg::CFG_RANK: begin
            rank_r <= cfg_data[ttb_pkg::RANK_W-1:0];
          end
          [ttb_pkg::CFG_SIZE0:ttb_pkg::CFG_SIZE5]: begin
            size_r[DIM_W'(cfg_index - ttb_pkg::CFG_SIZE0)] <= cfg_data[SIZE_W-1:0];
          end
          ttb_pkg::CFG_PERM: begin
            perm_r <= cfg_data[ttb_pkg::PERM_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    off_r        <= off_nxt;
    val_r        <= val_nxt;
    count_r      <= count_nxt;
    dim_r        <= dim_nxt;
    rem_r        <= rem_nxt;
    ext_r        <= ext_nxt;
    div_q_r      <= div_q_nxt;
    div_p_r      <= div_p_nxt;
    step_r       <= step_nxt;
    src_idx_r    <= src_idx_nxt;
    taken_r      <= taken_nxt;
    src_off_r    <= src_off_nxt;
    stride_r     <= stride_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // Source tensor storage
  ttb_ram #(
    .WIDTH (ttb_pkg::DATA_W),
    .DEPTH (ttb_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (val_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd_data)
  );

endmodule

// File: rtl/ttb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ttb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ttb_checker.sv
// Port-level checks for the tensor transpose buffer, bound to the top level.
module ttb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ttb_pkg::VALUE_W-1:0] out_tdata,
  input logic                        out_tuser
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An error result carries zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ttb_pkg::STAT_ERR |-> out_tdata == '0)
    else $error("error result with nonzero data");

  // One request in flight: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

endmodule

bind tensor_transpose_buffer ttb_checker u_ttb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
